### rtl/core/vlbp_pkg.sv
// ----------------------------------------------------------------------------
// vlbp_pkg
// Shared types and constants of the variable-length bit packer.
// ----------------------------------------------------------------------------
package vlbp_pkg;

   localparam int WORD_BITS     = 32;
   localparam int LEN_BITS      = 6;
   localparam int MAX_CODE_BITS = 32;
   localparam int BYTE_BITS     = 8;
   localparam int FILL_BITS     = 3;
   localparam int STEP_BITS     = 4;

   localparam logic ORDER_MSB_FIRST = 1'b0;
   localparam logic ORDER_LSB_FIRST = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic emits;
      logic done;
   } status_type;

endpackage

### rtl/core/vlbp_datapath.sv
// ----------------------------------------------------------------------------
// vlbp_datapath
// Code word register, partial byte, fill count, bit order and output payload.
// ----------------------------------------------------------------------------
module vlbp_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   input  logic [vlbp_pkg::WORD_BITS-1:0]  code_word,
   input  logic [vlbp_pkg::LEN_BITS-1:0]   code_length,
   input  vlbp_pkg::cmd_type               cmd,
   output vlbp_pkg::status_type            status,
   output logic [vlbp_pkg::BYTE_BITS-1:0]  out_byte,
   output logic                            out_last
);

   localparam logic [vlbp_pkg::LEN_BITS-1:0]  MAX_LEN =
      vlbp_pkg::LEN_BITS'(vlbp_pkg::MAX_CODE_BITS);
   localparam logic [vlbp_pkg::LEN_BITS-1:0]  WORD_LEN =
      vlbp_pkg::LEN_BITS'(vlbp_pkg::WORD_BITS);
   localparam logic [vlbp_pkg::STEP_BITS-1:0] BYTE_LEN =
      vlbp_pkg::STEP_BITS'(vlbp_pkg::BYTE_BITS);

   logic [vlbp_pkg::WORD_BITS-1:0] word_ff, word_in;
   logic [vlbp_pkg::LEN_BITS-1:0]  rem_ff, rem_in;
   logic [vlbp_pkg::BYTE_BITS-1:0] partial_ff, partial_in;
   logic [vlbp_pkg::FILL_BITS-1:0] fill_ff, fill_in;
   logic                           order_ff, order_in;
   logic [vlbp_pkg::BYTE_BITS-1:0] out_byte_ff, out_byte_in;
   logic                           out_last_ff, out_last_in;

   logic [vlbp_pkg::LEN_BITS-1:0]  len_sat;
   logic [vlbp_pkg::STEP_BITS-1:0] space;
   logic [vlbp_pkg::STEP_BITS-1:0] take;
   logic [vlbp_pkg::BYTE_BITS:0]   mask_wide;
   logic [vlbp_pkg::BYTE_BITS-1:0] chunk;
   logic [vlbp_pkg::BYTE_BITS-1:0] placed;
   logic [vlbp_pkg::BYTE_BITS-1:0] merged;
   logic [vlbp_pkg::LEN_BITS-1:0]  rem_next;
   logic                           emits;

   always_comb begin
      len_sat   = (code_length > MAX_LEN) ? MAX_LEN : code_length;
      space     = BYTE_LEN - {1'b0, fill_ff};
      take      = (rem_ff < {2'b00, space}) ? rem_ff[vlbp_pkg::STEP_BITS-1:0] : space;
      mask_wide = ((vlbp_pkg::BYTE_BITS+1)'(1) << take) - (vlbp_pkg::BYTE_BITS+1)'(1);
      if (order_ff == vlbp_pkg::ORDER_MSB_FIRST) begin
         chunk  = word_ff[vlbp_pkg::WORD_BITS-1 -: vlbp_pkg::BYTE_BITS] >> (BYTE_LEN - take);
         placed = chunk << (space - take);
      end else begin
         chunk  = word_ff[vlbp_pkg::BYTE_BITS-1:0] & mask_wide[vlbp_pkg::BYTE_BITS-1:0];
         placed = chunk << fill_ff;
      end
      merged   = partial_ff | placed;
      emits    = (take == space);
      rem_next = rem_ff - {2'b00, take};
   end

   assign status.emits = emits;
   assign status.done  = (rem_next == '0);

   always_comb begin
      order_in    = csr_wr_en ? csr_wr_data : order_ff;
      word_in     = word_ff;
      rem_in      = rem_ff;
      partial_in  = partial_ff;
      fill_in     = fill_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (cmd.load) begin
         rem_in = len_sat;
         if (order_ff == vlbp_pkg::ORDER_MSB_FIRST) begin
            word_in = code_word << (WORD_LEN - len_sat);
         end else begin
            word_in = code_word;
         end
      end else if (cmd.step) begin
         rem_in = rem_next;
         if (order_ff == vlbp_pkg::ORDER_MSB_FIRST) begin
            word_in = word_ff << take;
         end else begin
            word_in = word_ff >> take;
         end
         if (emits) begin
            partial_in  = '0;
            fill_in     = '0;
            out_byte_in = merged;
            out_last_in = (rem_next < vlbp_pkg::LEN_BITS'(vlbp_pkg::BYTE_BITS));
         end else begin
            partial_in = merged;
            fill_in    = fill_ff + take[vlbp_pkg::FILL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         fill_ff    <= '0;
         order_ff   <= vlbp_pkg::ORDER_MSB_FIRST;
      end else begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
         order_ff   <= order_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rem_ff      <= rem_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_byte = out_byte_ff;
   assign out_last = out_last_ff;

endmodule

### rtl/core/vlbp_ctrl.sv
// ----------------------------------------------------------------------------
// vlbp_ctrl
// Controller: input handshake, byte step sequencing and output valid.
// ----------------------------------------------------------------------------
module vlbp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  vlbp_pkg::status_type  status,
   output vlbp_pkg::cmd_type     cmd
);

   vlbp_pkg::state_type state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   logic                can_step;

   assign can_step = (state_ff == vlbp_pkg::ST_RUN) &&
                     (!status.emits || !out_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vlbp_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = vlbp_pkg::ST_RUN;
         end
         vlbp_pkg::ST_RUN: begin
            if (can_step && status.done) state_in = vlbp_pkg::ST_IDLE;
         end
         default: state_in = vlbp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == vlbp_pkg::ST_IDLE);
      cmd.load   = req_tready && req_tvalid;
      cmd.step   = can_step;
      if (can_step && status.emits) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vlbp_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && status.emits) |-> !cmd.step)
      else $error("byte step would overwrite a pending item");

   a_load_to_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == vlbp_pkg::ST_RUN))
      else $error("accepted item did not start a run");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.done) |=> (state_ff == vlbp_pkg::ST_IDLE))
      else $error("run did not end after its final step");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.step)
      else $error("load and step in the same cycle");

endmodule

### rtl/core/variable_length_bit_packer.sv
// ----------------------------------------------------------------------------
// variable_length_bit_packer
// Appends 0 to 32 code bits per item to a running byte and emits whole bytes.
// ----------------------------------------------------------------------------
// One item is taken in an idle cycle, then the datapath places up to eight bits
// per cycle into the partial byte while the result side does not stall, taking
// a step for each completed byte plus a final step when bits are left over or
// the length is zero. The next item is accepted once the last step of the
// current one is done, while its final byte may still wait in the output
// register. code_length above 32 saturates to 32; bit_order selects MSB-first
// (0) or LSB-first (1) and should be changed only while idle.
// ----------------------------------------------------------------------------
module variable_length_bit_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,   // bit_order
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,     // [31:0] code_word, [37:32] code_length, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // [7:0] out_byte
   output logic        rsp_tlast      // last_of_run
);

   vlbp_pkg::cmd_type    cmd;
   vlbp_pkg::status_type status;

   vlbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vlbp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .code_word   (req_tdata[31:0]),
      .code_length (req_tdata[37:32]),
      .cmd         (cmd),
      .status      (status),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule
